/* src/mlf_pkg.sv */
`timescale 1ns / 1ps

package mlf_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int NUM_PORTS       = 8;
    localparam int MAC_W           = 48;
    localparam int PORT_W          = 3;
    localparam int MASK_W          = 8;
    localparam int LANES           = 32;
    localparam int LANE_W          = $clog2(LANES);
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [MAC_W-1:0]  BCAST_ADDR = {MAC_W{1'b1}};
    localparam logic [MASK_W-1:0] EXIST_MASK =
        (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

    localparam logic [MASK_W-1:0] PORT_ENABLE_RST = 8'hFF;
    localparam logic [MASK_W-1:0] BLOCKED_RST     = 8'h00;

    // register index, taken from paddr[2]
    localparam logic REG_PORT_ENABLE = 1'b0;
    localparam logic REG_BLOCKED     = 1'b1;

    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] ingress_port;
    } hdr_t;

    typedef struct packed {
        logic [MASK_W-1:0] egress_mask;
        logic              dest_known;
        logic              is_broadcast;
        logic              learn_dropped;
    } fwd_t;

    typedef struct packed {
        logic [MASK_W-1:0] port_enable;
        logic [MASK_W-1:0] blocked;
    } regs_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic learn;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic table_empty;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

/* src/mlf_regs.sv */
`timescale 1ns / 1ps

module mlf_regs
    import mlf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output regs_t              regs
);

    logic [MASK_W-1:0] port_enable_reg;
    logic [MASK_W-1:0] blocked_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_enable_reg <= PORT_ENABLE_RST;
            blocked_reg     <= BLOCKED_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_PORT_ENABLE: port_enable_reg <= pwdata[MASK_W-1:0];
                REG_BLOCKED:     blocked_reg     <= pwdata[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PORT_ENABLE: prdata = {{(PDATA_W-MASK_W){1'b0}}, port_enable_reg};
            REG_BLOCKED:     prdata = {{(PDATA_W-MASK_W){1'b0}}, blocked_reg};
            default:         prdata = '0;
        endcase
    end

    assign regs.port_enable = port_enable_reg;
    assign regs.blocked     = blocked_reg;

endmodule

/* src/mlf_ctrl.sv */
`timescale 1ns / 1ps

module mlf_ctrl
    import mlf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic hdr_valid,
    output logic hdr_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_LEARN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        hdr_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                hdr_ready = 1'b1;
                if (hdr_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.table_empty)
                begin
                    state_next = ST_LEARN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            // last row still in the compare stage
            ST_DRAIN:
            begin
                state_next = ST_LEARN;
            end
            ST_LEARN:
            begin
                cmd.learn  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/mlf_datapath.sv */
`timescale 1ns / 1ps

module mlf_datapath
    import mlf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  hdr_t hdr,
    input  regs_t regs,
    input  cmd_t cmd,
    output sts_t sts,
    output logic fwd_valid,
    input  logic fwd_ready,
    output fwd_t fwd
);

    localparam int ROWS   = (TABLE_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W = ROW_W + LANE_W;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [LANES-1:0][MAC_W-1:0]  mac_mem  [ROWS];
    logic [LANES-1:0][PORT_W-1:0] port_mem [ROWS];

    hdr_t                         item_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [ROW_W-1:0]             rd_row_reg;
    logic [ROW_W-1:0]             row_q_reg;
    logic                         cmp_valid_reg;
    logic [LANES-1:0][MAC_W-1:0]  mac_q_reg;
    logic [LANES-1:0][PORT_W-1:0] port_q_reg;
    logic                         src_hit_reg;
    logic [ROW_W-1:0]             src_row_reg;
    logic [LANE_W-1:0]            src_lane_reg;
    logic                         dst_hit_reg;
    logic [PORT_W-1:0]            dst_port_reg;
    fwd_t                         res_reg;
    fwd_t                         out_reg;
    logic                         out_valid_reg;

    logic [SLOT_W-1:0]            last_slot;
    logic [ROW_W-1:0]             last_row;
    logic [LANE_W-1:0]            last_lane;
    logic [SLOT_W-1:0]            app_slot;
    logic [ROW_W-1:0]             app_row;
    logic [LANE_W-1:0]            app_lane;
    logic                         table_full;
    logic [LANES-1:0]             lane_ok;
    logic                         src_any;
    logic [LANE_W-1:0]            src_lane;
    logic                         dst_any;
    logic [PORT_W-1:0]            dst_port;

    logic                         bcast;
    logic                         dst_is_src;
    logic                         dropped;
    logic                         known;
    logic [PORT_W-1:0]            known_port;
    logic [MASK_W-1:0]            base_mask;
    logic [MASK_W-1:0]            mask;

    assign last_slot  = SLOT_W'(count_reg - CNT_W'(1));
    assign last_row   = last_slot[SLOT_W-1:LANE_W];
    assign last_lane  = last_slot[LANE_W-1:0];
    assign app_slot   = SLOT_W'(count_reg);
    assign app_row    = app_slot[SLOT_W-1:LANE_W];
    assign app_lane   = app_slot[LANE_W-1:0];
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    assign sts.table_empty = (count_reg == '0);
    assign sts.scan_last   = (rd_row_reg == last_row);
    assign sts.out_free    = !out_valid_reg || fwd_ready;

    // entries past the fill count only live in the last scanned row
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_ok[l] = (row_q_reg != last_row) || (LANE_W'(l) <= last_lane);
        end
    end

    always_comb
    begin
        src_any  = 1'b0;
        src_lane = '0;
        dst_any  = 1'b0;
        dst_port = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (lane_ok[l] && (mac_q_reg[l] == item_reg.src_mac))
            begin
                src_any  = 1'b1;
                src_lane = LANE_W'(l);
            end
            if (lane_ok[l] && (mac_q_reg[l] == item_reg.dst_mac))
            begin
                dst_any  = 1'b1;
                dst_port = port_q_reg[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mac_q_reg <= mac_mem[rd_row_reg];
        end
        if (cmd.learn && !src_hit_reg && !table_full)
        begin
            mac_mem[app_row][app_lane] <= item_reg.src_mac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            port_q_reg <= port_mem[rd_row_reg];
        end
        if (cmd.learn)
        begin
            if (src_hit_reg)
            begin
                port_mem[src_row_reg][src_lane_reg] <= item_reg.ingress_port;
            end
            else if (!table_full)
            begin
                port_mem[app_row][app_lane] <= item_reg.ingress_port;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.rd_en;
            if (cmd.learn && !src_hit_reg && !table_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (fwd_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg    <= hdr;
            rd_row_reg  <= '0;
            src_hit_reg <= 1'b0;
            dst_hit_reg <= 1'b0;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= rd_row_reg + ROW_W'(1);
            row_q_reg  <= rd_row_reg;
        end
        if (cmp_valid_reg)
        begin
            if (src_any)
            begin
                src_hit_reg  <= 1'b1;
                src_row_reg  <= row_q_reg;
                src_lane_reg <= src_lane;
            end
            if (dst_any)
            begin
                dst_hit_reg  <= 1'b1;
                dst_port_reg <= dst_port;
            end
        end
        if (cmd.learn)
        begin
            res_reg <= '{egress_mask: mask, dest_known: known,
                         is_broadcast: bcast, learn_dropped: dropped};
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // the source is learned first, so a destination equal to it sits on the ingress port
    assign bcast      = (item_reg.dst_mac == BCAST_ADDR);
    assign dst_is_src = (item_reg.dst_mac == item_reg.src_mac);
    assign dropped    = !src_hit_reg && table_full;
    assign known      = !bcast && (dst_is_src ? !dropped : dst_hit_reg);
    assign known_port = dst_is_src ? item_reg.ingress_port : dst_port_reg;
    assign base_mask  = known ? (MASK_W'(1) << known_port) : {MASK_W{1'b1}};
    assign mask       = base_mask & EXIST_MASK & regs.port_enable & ~regs.blocked
                        & ~(MASK_W'(1) << item_reg.ingress_port);

    assign fwd_valid = out_valid_reg;
    assign fwd       = out_reg;

endmodule

/* src/mac_learning_forwarder.sv */
`timescale 1ns / 1ps
// per header: capture, scan and drain of filled rows, learn, then output register load
// the table is read one 32-entry row per cycle through the scan port, src and dst compared together
// one header at a time: no new header is taken until its result goes to the output register
// the next header is taken while the previous result waits in the output register
// reset (async, active low) empties the table; link mask resets to 0xff, blocked mask to 0x00

module mac_learning_forwarder
    import mlf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               hdr_valid,
    output logic               hdr_ready,
    input  hdr_t               hdr,
    output logic               fwd_valid,
    input  logic               fwd_ready,
    output fwd_t               fwd
);

    regs_t regs;
    cmd_t  cmd;
    sts_t  sts;

    mlf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    mlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mlf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .regs      (regs),
        .cmd       (cmd),
        .sts       (sts),
        .fwd_valid (fwd_valid),
        .fwd_ready (fwd_ready),
        .fwd       (fwd)
    );

endmodule

/* src/mlf_checker.sv */
`timescale 1ns / 1ps

module mlf_checker
    import mlf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready,
    input logic               hdr_valid,
    input logic               hdr_ready,
    input logic               fwd_valid,
    input logic               fwd_ready
);

    // a result word stays up until taken
    a_fwd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid && !fwd_ready |=> fwd_valid)
        else $error("result word dropped before it was taken");

    // one header at a time: busy right after a header word is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_ready |=> !hdr_ready)
        else $error("header taken while the previous one is in work");

    // a result cannot rise right after a header word is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_valid) |-> !$past(hdr_valid && hdr_ready, 1)
                             && !$past(hdr_valid && hdr_ready, 2))
        else $error("result appeared too soon after a header");

    // a written link mask reads back at once
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready && !paddr[2])
        && psel && !pwrite && !paddr[2]
        |-> prdata == {{(PDATA_W-MASK_W){1'b0}}, $past(pwdata[MASK_W-1:0])})
        else $error("link mask readback mismatch");

endmodule

bind mac_learning_forwarder mlf_checker u_mlf_checker (.*);
